FILE: design/fnb_pkg.sv
// ---------------------------------------------------------------------------
// fnb_pkg: shared types and constants
// Sequencer states, operation codes and fixed widths of the shared units.
// ---------------------------------------------------------------------------
package fnb_pkg;

  localparam int MUL_W     = 32;
  localparam int WIDE_W    = 64;
  localparam int NORM_BITS = 30;

  localparam logic             OP_ADD   = 1'b0;
  localparam logic             OP_CLEAR = 1'b1;
  localparam logic [1:0]       TRI_MODE = 2'd3;

  // normalization window for the largest cross product magnitude
  localparam logic [WIDE_W-1:0] NORM_TOP     = 64'h1 << NORM_BITS;
  localparam logic [WIDE_W-1:0] NORM_BOT     = 64'h1 << (NORM_BITS - 1);
  localparam logic [WIDE_W-1:0] NORM_FAR_TOP = 64'h1 << (NORM_BITS + 4);
  localparam logic [WIDE_W-1:0] NORM_FAR_BOT = 64'h1 << (NORM_BITS - 5);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CROSS,
    ST_NORM,
    ST_SQUARE,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

endpackage

FILE: design/fnb_mul.sv
// ---------------------------------------------------------------------------
// fnb_mul: shared multiplier
// Unsigned 32x32 multiply with a registered 64-bit product.
// ---------------------------------------------------------------------------
module fnb_mul import fnb_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [WIDE_W-1:0] p
);

  // register the product for the next step
  always_ff @(posedge clk) begin
    p <= {{(WIDE_W-MUL_W){1'b0}}, a} * {{(WIDE_W-MUL_W){1'b0}}, b};
  end

endmodule

FILE: design/fnb_sqrt.sv
// ---------------------------------------------------------------------------
// fnb_sqrt: iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
module fnb_sqrt import fnb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WIDE_W-1:0] x,
  output logic              done,
  output logic [MUL_W-1:0]  root
);

  logic [WIDE_W-1:0] rem;
  logic [WIDE_W-1:0] r;
  logic [WIDE_W-1:0] bitv;
  logic [WIDE_W-1:0] trial;
  logic              run;

  assign trial = r + bitv;
  assign root  = r[MUL_W-1:0];

  // control: run for one step per bit pair
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && bitv[0];
      if (start) begin
        run <= 1'b1;
      end else if (run && bitv[0]) begin
        run <= 1'b0;
      end
    end
  end

  // datapath: subtract trial value when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= x;
      r    <= '0;
      bitv <= 64'h1 << (WIDE_W - 2);
    end else if (run) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        r   <= (r >> 1) + bitv;
      end else begin
        r   <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

FILE: design/fnb_div.sv
// ---------------------------------------------------------------------------
// fnb_div: iterative restoring divider
// Quotient of a 64-bit numerator by a 32-bit divisor, one bit per cycle.
// ---------------------------------------------------------------------------
module fnb_div import fnb_pkg::*; #(
  parameter int QW = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WIDE_W-1:0] num,
  input  logic [MUL_W-1:0]  den,
  output logic              done,
  output logic [QW-1:0]     quo
);

  localparam int CW = $clog2(QW + 1);

  logic [MUL_W:0]   rem;
  logic [QW-1:0]    nlow;
  logic [CW-1:0]    cnt;
  logic [MUL_W:0]   trial;
  logic             fits;
  logic             run;

  assign trial = {rem[MUL_W-1:0], nlow[QW-1]};
  assign fits  = trial >= {1'b0, den};

  // control: count quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CW'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(QW);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // datapath: shift in a numerator bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= (MUL_W+1)'(num >> QW);
      nlow <= num[QW-1:0];
      quo  <= '0;
    end else if (run) begin
      rem  <= fits ? (trial - {1'b0, den}) : trial;
      nlow <= nlow << 1;
      quo  <= {quo[QW-2:0], fits};
    end
  end

endmodule

FILE: design/face_normal_and_bounds.sv
// ---------------------------------------------------------------------------
// face_normal_and_bounds: triangle face normal and running bounding box
// Unit face normal of one element per request plus box and element count.
// ---------------------------------------------------------------------------
// Channel  | Direction | Handshake           | Payload
// cfg      | in        | cfg_wr_en           | cfg_wr_data (vertices per element)
// in       | in        | in_valid / in_stall | operation, vertex0..2 x/y/z
// out      | out       | out_valid/out_stall | normal x/y/z, degenerate, count, box
//
// In an add request the shared multiplier runs six cross terms and three squares,
// then the bit-serial square root runs once and the divider once per component.
// A clear request skips the arithmetic. Degenerate elements finish after the cross.
// in_stall is high while a request is in work; a stalled result waits in its
// output register while the next request may already be accepted.
// Reset is synchronous: empty box, zero count, three vertices per element.
// ---------------------------------------------------------------------------
module face_normal_and_bounds import fnb_pkg::*; #(
  parameter int COORD_WIDTH      = 20,
  parameter int NORMAL_FRAC_BITS = 15,
  parameter int COUNT_WIDTH      = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic signed [COORD_WIDTH-1:0] vertex0_x,
  input  logic signed [COORD_WIDTH-1:0] vertex0_y,
  input  logic signed [COORD_WIDTH-1:0] vertex0_z,
  input  logic signed [COORD_WIDTH-1:0] vertex1_x,
  input  logic signed [COORD_WIDTH-1:0] vertex1_y,
  input  logic signed [COORD_WIDTH-1:0] vertex1_z,
  input  logic signed [COORD_WIDTH-1:0] vertex2_x,
  input  logic signed [COORD_WIDTH-1:0] vertex2_y,
  input  logic signed [COORD_WIDTH-1:0] vertex2_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [NORMAL_FRAC_BITS:0] normal_x,
  output logic signed [NORMAL_FRAC_BITS:0] normal_y,
  output logic signed [NORMAL_FRAC_BITS:0] normal_z,
  output logic                          degenerate,
  output logic [COUNT_WIDTH-1:0]        element_count,
  output logic                          bounds_valid,
  output logic signed [COORD_WIDTH-1:0] min_x,
  output logic signed [COORD_WIDTH-1:0] min_y,
  output logic signed [COORD_WIDTH-1:0] min_z,
  output logic signed [COORD_WIDTH-1:0] max_x,
  output logic signed [COORD_WIDTH-1:0] max_y,
  output logic signed [COORD_WIDTH-1:0] max_z
);

  localparam int ES = (COORD_WIDTH > 31) ? (COORD_WIDTH - 31) : 0;
  localparam int MW = COORD_WIDTH + 1 - ES;
  localparam int NW = NORMAL_FRAC_BITS + 1;
  localparam int QW = NORMAL_FRAC_BITS + 2;
  localparam logic [QW-1:0] ONE = QW'(1) << NORMAL_FRAC_BITS;

  state_t state, state_next;

  logic [1:0]  vpe;
  logic        tri_mode;
  logic [2:0]  step;
  logic [1:0]  comp;
  logic        in_acc;
  logic        out_acc;
  logic        out_load;

  logic signed [COORD_WIDTH-1:0] vin [0:2][0:2];
  logic signed [COORD_WIDTH-1:0] vert [0:2][0:2];
  logic signed [COORD_WIDTH-1:0] lo [0:2];
  logic signed [COORD_WIDTH-1:0] hi [0:2];
  logic        nonempty;
  logic [COUNT_WIDTH-1:0] count;

  logic [MW-1:0] e1m [0:2];
  logic [MW-1:0] e2m [0:2];
  logic          e1s [0:2];
  logic          e2s [0:2];
  logic [MW-1:0] e1m_in [0:2];
  logic [MW-1:0] e2m_in [0:2];
  logic          e1s_in [0:2];
  logic          e2s_in [0:2];

  logic [WIDE_W-1:0] cprod [0:2];
  logic [WIDE_W-1:0] mag [0:2];
  logic              csign [0:2];
  logic [WIDE_W-1:0] m01, mmax;
  logic [WIDE_W-1:0] sum;
  logic [NW-1:0]     nrm [0:2];
  logic              degen;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [WIDE_W-1:0] prod;
  logic [WIDE_W-1:0] sprod;
  logic              op_sign;
  logic              op_term;
  logic [1:0]        op_comp;
  logic              psign, pterm;
  logic [1:0]        pcomp;

  logic              sq_start, sq_done;
  logic              dv_start, dv_done;
  logic [MUL_W-1:0]  root;
  logic [WIDE_W-1:0] div_num;
  logic [QW-1:0]     quo;
  logic [QW-1:0]     qsat;
  logic [NW-1:0]     nval;

  assign tri_mode = (vpe == TRI_MODE);
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  assign vin[0][0] = vertex0_x; assign vin[0][1] = vertex0_y; assign vin[0][2] = vertex0_z;
  assign vin[1][0] = vertex1_x; assign vin[1][1] = vertex1_y; assign vin[1][2] = vertex1_z;
  assign vin[2][0] = vertex2_x; assign vin[2][1] = vertex2_y; assign vin[2][2] = vertex2_z;

  // edge magnitudes and signs of the incoming vertices
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [COORD_WIDTH:0] d1, d2;
      logic [COORD_WIDTH:0]        a1, a2;
      d1 = {vin[1][k][COORD_WIDTH-1], vin[1][k]} - {vin[0][k][COORD_WIDTH-1], vin[0][k]};
      d2 = tri_mode ?
           ({vin[2][k][COORD_WIDTH-1], vin[2][k]} - {vin[0][k][COORD_WIDTH-1], vin[0][k]}) :
           d1;
      a1 = d1[COORD_WIDTH] ? (COORD_WIDTH+1)'(-d1) : d1;
      a2 = d2[COORD_WIDTH] ? (COORD_WIDTH+1)'(-d2) : d2;
      e1m_in[k] = MW'(a1 >> ES);
      e2m_in[k] = MW'(a2 >> ES);
      e1s_in[k] = d1[COORD_WIDTH];
      e2s_in[k] = d2[COORD_WIDTH];
    end
  end

  // largest cross product magnitude
  assign m01  = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign mmax = (m01 > mag[2]) ? m01 : mag[2];

  // shared multiplier operand selection
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    op_sign = 1'b0;
    op_term = step[0];
    op_comp = 2'(step >> 1);
    if (state == ST_CROSS) begin
      case (step)
        3'd0: begin
          mul_a = MUL_W'(e1m[1]); mul_b = MUL_W'(e2m[2]); op_sign = e1s[1] ^ e2s[2];
        end
        3'd1: begin
          mul_a = MUL_W'(e1m[2]); mul_b = MUL_W'(e2m[1]); op_sign = e1s[2] ^ e2s[1];
        end
        3'd2: begin
          mul_a = MUL_W'(e1m[2]); mul_b = MUL_W'(e2m[0]); op_sign = e1s[2] ^ e2s[0];
        end
        3'd3: begin
          mul_a = MUL_W'(e1m[0]); mul_b = MUL_W'(e2m[2]); op_sign = e1s[0] ^ e2s[2];
        end
        3'd4: begin
          mul_a = MUL_W'(e1m[0]); mul_b = MUL_W'(e2m[1]); op_sign = e1s[0] ^ e2s[1];
        end
        3'd5: begin
          mul_a = MUL_W'(e1m[1]); mul_b = MUL_W'(e2m[0]); op_sign = e1s[1] ^ e2s[0];
        end
        default: begin
          mul_a = '0;
        end
      endcase
    end else if (state == ST_SQUARE && step < 3'd3) begin
      mul_a = mag[step[1:0]][MUL_W-1:0];
      mul_b = mag[step[1:0]][MUL_W-1:0];
    end
  end

  fnb_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign sprod = psign ? (WIDE_W'(0) - prod) : prod;

  fnb_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (sum),
    .done  (sq_done),
    .root  (root)
  );

  assign div_num = (mag[comp] << NORMAL_FRAC_BITS) + {{(WIDE_W-MUL_W+1){1'b0}}, root[MUL_W-1:1]};

  fnb_div #(.QW(QW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (div_num),
    .den   (root),
    .done  (dv_done),
    .quo   (quo)
  );

  // saturate the quotient and apply the sign
  always_comb begin
    if (csign[comp]) begin
      qsat = (quo > ONE) ? ONE : quo;
      nval = NW'(0) - qsat[NW-1:0];
    end else begin
      qsat = (quo > ONE - QW'(1)) ? (ONE - QW'(1)) : quo;
      nval = qsat[NW-1:0];
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    sq_start   = 1'b0;
    dv_start   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (operation == OP_CLEAR) ? ST_DONE : ST_CROSS;
        end
      end
      ST_CROSS: begin
        if (step == 3'd6) state_next = ST_NORM;
      end
      ST_NORM: begin
        if (step != 3'd0) begin
          if (mmax == '0) begin
            state_next = ST_DONE;
          end else if (mmax < NORM_TOP && mmax >= NORM_BOT) begin
            state_next = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        if (step == 3'd3) state_next = ST_SQRT_GO;
      end
      ST_SQRT_GO: begin
        sq_start   = 1'b1;
        state_next = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sq_done) state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        dv_start   = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (dv_done) state_next = (comp == 2'd2) ? ST_DONE : ST_DIV_GO;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // step counter: restart on every state change
  always_ff @(posedge clk) begin
    if (rst || state_next != state) step <= '0;
    else if (step != 3'd7)          step <= step + 3'd1;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst)            vpe <= TRI_MODE;
    else if (cfg_wr_en) vpe <= cfg_wr_data;
  end

  // box and count
  always_ff @(posedge clk) begin
    if (rst || (in_acc && operation == OP_CLEAR)) begin
      for (int k = 0; k < 3; k++) begin
        lo[k] <= '0;
        hi[k] <= '0;
      end
      nonempty <= 1'b0;
      count    <= '0;
    end else begin
      if (in_acc && count != {COUNT_WIDTH{1'b1}}) count <= count + COUNT_WIDTH'(1);
      if (state == ST_CROSS && (step < 3'd2 || (step == 3'd2 && tri_mode))) begin
        for (int k = 0; k < 3; k++) begin
          if (!nonempty || vert[step[1:0]][k] < lo[k]) lo[k] <= vert[step[1:0]][k];
          if (!nonempty || vert[step[1:0]][k] > hi[k]) hi[k] <= vert[step[1:0]][k];
        end
        nonempty <= 1'b1;
      end
    end
  end

  // latch vertices and edges
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) vert[i][k] <= vin[i][k];
        e1m[k] <= e1m_in[k];
        e2m[k] <= e2m_in[k];
        e1s[k] <= e1s_in[k];
        e2s[k] <= e2s_in[k];
      end
    end
  end

  // pending product tags
  always_ff @(posedge clk) begin
    psign <= op_sign;
    pterm <= op_term;
    pcomp <= op_comp;
  end

  // cross accumulate, normalize, square sum, divide results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      degen <= 1'b0;
      comp  <= 2'd0;
      for (int k = 0; k < 3; k++) nrm[k] <= '0;
    end
    case (state)
      ST_CROSS: begin
        if (step != 3'd0) begin
          if (!pterm) cprod[pcomp] <= sprod;
          else        cprod[pcomp] <= cprod[pcomp] - sprod;
        end
      end
      ST_NORM: begin
        if (step == 3'd0) begin
          for (int k = 0; k < 3; k++) begin
            mag[k]   <= cprod[k][WIDE_W-1] ? (WIDE_W'(0) - cprod[k]) : cprod[k];
            csign[k] <= cprod[k][WIDE_W-1];
          end
        end else if (mmax == '0) begin
          degen <= 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (mmax >= NORM_FAR_TOP)     mag[k] <= mag[k] >> 4;
            else if (mmax >= NORM_TOP)    mag[k] <= mag[k] >> 1;
            else if (mmax < NORM_FAR_BOT) mag[k] <= mag[k] << 4;
            else if (mmax < NORM_BOT)     mag[k] <= mag[k] << 1;
          end
        end
      end
      ST_SQUARE: begin
        if (step == 3'd1)      sum <= prod;
        else if (step != 3'd0) sum <= sum + prod;
      end
      ST_DIV_WAIT: begin
        if (dv_done) begin
          nrm[comp] <= nval;
          comp      <= comp + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      normal_x      <= nrm[0];
      normal_y      <= nrm[1];
      normal_z      <= nrm[2];
      degenerate    <= degen;
      element_count <= count;
      bounds_valid  <= nonempty;
      min_x         <= lo[0];
      min_y         <= lo[1];
      min_z         <= lo[2];
      max_x         <= hi[0];
      max_y         <= hi[1];
      max_z         <= hi[2];
    end
  end

endmodule

FILE: design/fnb_checker.sv
// ---------------------------------------------------------------------------
// fnb_checker: port-level checks
// Watches the result channel of the face normal and bounds block.
// ---------------------------------------------------------------------------
module fnb_checker import fnb_pkg::*; #(
  parameter int COORD_WIDTH      = 20,
  parameter int NORMAL_FRAC_BITS = 15,
  parameter int COUNT_WIDTH      = 32
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [NORMAL_FRAC_BITS:0] normal_x,
  input logic signed [NORMAL_FRAC_BITS:0] normal_y,
  input logic signed [NORMAL_FRAC_BITS:0] normal_z,
  input logic                             degenerate,
  input logic [COUNT_WIDTH-1:0]           element_count,
  input logic                             bounds_valid,
  input logic signed [COORD_WIDTH-1:0]    min_x,
  input logic signed [COORD_WIDTH-1:0]    max_x
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(element_count) && $stable(normal_x))
    else $error("stalled result changed");

  // degenerate results carry a zero normal
  assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
    else $error("degenerate result with nonzero normal");

  // an empty box goes with a zero count
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (element_count == 0) == !bounds_valid)
    else $error("count and box disagree");

  // a filled box is ordered in x
  assert property (@(posedge clk) disable iff (rst)
    out_valid && bounds_valid |-> min_x <= max_x)
    else $error("box minimum above maximum");

endmodule

bind face_normal_and_bounds fnb_checker #(
  .COORD_WIDTH      (COORD_WIDTH),
  .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
  .COUNT_WIDTH      (COUNT_WIDTH)
) u_fnb_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .normal_x      (normal_x),
  .normal_y      (normal_y),
  .normal_z      (normal_z),
  .degenerate    (degenerate),
  .element_count (element_count),
  .bounds_valid  (bounds_valid),
  .min_x         (min_x),
  .max_x         (max_x)
);

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: face normal and bounding box testbench
// Drives element and clear requests through the valid/stall channel, predicts
// the unit normal, count and box for each one, and compares each result in
// order. Covers both vertex-count settings, degenerate and extreme elements,
// and several phases of sender idling and receiver stalling.
// ---------------------------------------------------------------------------
module tb;
  import fnb_pkg::*;

  localparam int CW = 20;
  localparam int FB = 15;
  localparam int NW = 32;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE = 200;

  typedef struct {
    logic signed [FB:0] nx, ny, nz;
    logic degen;
    logic [NW-1:0] count;
    logic box_ok;
    logic signed [CW-1:0] lox, loy, loz, hix, hiy, hiz;
  } face_result_t;

  logic clk = 0, rst = 1;
  logic cfg_wr_en = 0;
  logic [1:0] cfg_wr_data = 2'd3;
  logic in_valid = 0, out_stall = 0;
  logic operation = OP_ADD;
  logic signed [CW-1:0] v0x = 0, v0y = 0, v0z = 0, v1x = 0, v1y = 0, v1z = 0;
  logic signed [CW-1:0] v2x = 0, v2y = 0, v2z = 0;
  logic in_stall, out_valid, degenerate, bounds_valid;
  logic signed [FB:0] normal_x, normal_y, normal_z;
  logic [NW-1:0] element_count;
  logic signed [CW-1:0] min_x, min_y, min_z, max_x, max_y, max_z;

  face_normal_and_bounds uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .vertex0_x(v0x), .vertex0_y(v0y), .vertex0_z(v0z),
    .vertex1_x(v1x), .vertex1_y(v1y), .vertex1_z(v1z),
    .vertex2_x(v2x), .vertex2_y(v2y), .vertex2_z(v2z),
    .out_valid(out_valid), .out_stall(out_stall),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .degenerate(degenerate), .element_count(element_count),
    .bounds_valid(bounds_valid), .min_x(min_x), .min_y(min_y), .min_z(min_z),
    .max_x(max_x), .max_y(max_y), .max_z(max_z)
  );

  // predictor state
  logic [1:0] verts_cfg = 2'd3;
  longint box_lo[3], box_hi[3];
  bit box_filled = 0;
  logic [NW-1:0] seen_count = 0;
  face_result_t expected_faces[$];

  int send_idle = 0, recv_stall = 0;
  int errors = 0;
  int cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned bitv = 64'h1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // advance the box and count, and work out the normal for one request
  function automatic face_result_t predict_face(logic op, longint v[3][3]);
    face_result_t r;
    longint e1[3], e2[3], c[3], nrm[3];
    longint unsigned mag[3], m, sum, root, q, one;
    int used, last, b;
    nrm = '{0, 0, 0};
    r.degen = 0;
    if (op == OP_CLEAR) begin
      box_lo = '{0, 0, 0};
      box_hi = '{0, 0, 0};
      box_filled = 0;
      seen_count = 0;
    end else begin
      used = (verts_cfg == TRI_MODE) ? 3 : 2;
      last = used - 1;
      for (int i = 0; i < used; i++) begin
        for (int k = 0; k < 3; k++) begin
          if (!box_filled || v[i][k] < box_lo[k]) box_lo[k] = v[i][k];
          if (!box_filled || v[i][k] > box_hi[k]) box_hi[k] = v[i][k];
        end
        box_filled = 1;
      end
      if (seen_count != '1) seen_count++;
      for (int k = 0; k < 3; k++) begin
        e1[k] = v[1][k] - v[0][k];
        e2[k] = v[last][k] - v[0][k];
      end
      c[0] = e1[1] * e2[2] - e1[2] * e2[1];
      c[1] = e1[2] * e2[0] - e1[0] * e2[2];
      c[2] = e1[0] * e2[1] - e1[1] * e2[0];
      m = 0;
      for (int k = 0; k < 3; k++) begin
        mag[k] = c[k] < 0 ? -c[k] : c[k];
        if (mag[k] > m) m = mag[k];
      end
      if (m == 0) begin
        r.degen = 1;
      end else begin
        b = 0;
        while (b < 64 && (m >> b) != 0) b++;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
          if (b > NORM_BITS) mag[k] >>= (b - NORM_BITS);
          else mag[k] <<= (NORM_BITS - b);
          sum += mag[k] * mag[k];
        end
        root = int_sqrt(sum);
        one = 64'h1 << FB;
        for (int k = 0; k < 3; k++) begin
          q = ((mag[k] << FB) + root / 2) / root;
          if (c[k] < 0) begin
            if (q > one) q = one;
            nrm[k] = -q;
          end else begin
            if (q > one - 1) q = one - 1;
            nrm[k] = q;
          end
        end
      end
    end
    r.nx = (FB+1)'(nrm[0]);
    r.ny = (FB+1)'(nrm[1]);
    r.nz = (FB+1)'(nrm[2]);
    r.count = seen_count;
    r.box_ok = box_filled;
    r.lox = CW'(box_lo[0]); r.loy = CW'(box_lo[1]); r.loz = CW'(box_lo[2]);
    r.hix = CW'(box_hi[0]); r.hiy = CW'(box_hi[1]); r.hiz = CW'(box_hi[2]);
    return r;
  endfunction

  // send one request and hold it until accepted, then queue its prediction
  task automatic send_face(logic op, longint v[3][3]);
    operation <= op;
    v0x <= CW'(v[0][0]); v0y <= CW'(v[0][1]); v0z <= CW'(v[0][2]);
    v1x <= CW'(v[1][0]); v1y <= CW'(v[1][1]); v1z <= CW'(v[1][2]);
    v2x <= CW'(v[2][0]); v2y <= CW'(v[2][1]); v2z <= CW'(v[2][2]);
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    expected_faces.insert(expected_faces.size(), predict_face(op, v));
    // idle the sender at random
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  // hold off until every result is back and the block has settled
  task automatic drain();
    in_valid <= 0;
    while (expected_faces.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_verts(logic [1:0] val);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    verts_cfg = val;
  endtask

  // drive the stall and check each accepted result
  always @(posedge clk) begin
    face_result_t e;
    if (rst) begin
      out_stall <= 0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
      if (out_valid && !out_stall) begin
        if (expected_faces.size() == 0) begin
          $display("%0t: unexpected result, count %0d", $time, element_count);
          errors++;
        end else begin
          e = expected_faces.pop_front();
          if (normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz) begin
            $display("%0t: normal exp %0d %0d %0d act %0d %0d %0d", $time,
                     e.nx, e.ny, e.nz, normal_x, normal_y, normal_z);
            errors++;
          end
          if (degenerate !== e.degen || element_count !== e.count ||
              bounds_valid !== e.box_ok) begin
            $display("%0t: degen/count/valid exp %0d %0d %0d act %0d %0d %0d", $time,
                     e.degen, e.count, e.box_ok, degenerate, element_count,
                     bounds_valid);
            errors++;
          end
          if (min_x !== e.lox || min_y !== e.loy || min_z !== e.loz ||
              max_x !== e.hix || max_y !== e.hiy || max_z !== e.hiz) begin
            $display("%0t: box exp %0d %0d %0d / %0d %0d %0d act %0d %0d %0d / %0d %0d %0d",
                     $time, e.lox, e.loy, e.loz, e.hix, e.hiy, e.hiz,
                     min_x, min_y, min_z, max_x, max_y, max_z);
            errors++;
          end
        end
      end
    end
  end

  function automatic longint rand_coord();
    case ($urandom_range(9))
      0: return -524288;
      1: return 524287;
      2, 3: return $signed(CW'($urandom));
      default: return longint'($urandom_range(2000)) - 1000;
    endcase
  endfunction

  // random element, with coincident and collinear vertices now and then
  task automatic send_random_face();
    longint v[3][3];
    logic op;
    int shape;
    op = ($urandom_range(99) < 3) ? OP_CLEAR : OP_ADD;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) v[i][k] = rand_coord();
    shape = $urandom_range(19);
    if (shape == 0) v[1] = v[0];
    else if (shape == 1) v[2] = v[0];
    else if (shape == 2) v[2] = v[1];
    else if (shape == 3) begin
      for (int k = 0; k < 3; k++) begin
        v[0][k] = longint'($urandom_range(2000)) - 1000;
        v[1][k] = v[0][k] + longint'($urandom_range(200)) - 100;
        v[2][k] = v[0][k] + 3 * (v[1][k] - v[0][k]);
      end
    end
    send_face(op, v);
  endtask

  task automatic test_directed();
    longint v[3][3];
    longint hi = 524287, lo = -524288;
    v = '{'{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}};
    send_face(OP_ADD, v);
    v = '{'{0, 0, 0}, '{0, 1, 0}, '{1, 0, 0}};
    send_face(OP_ADD, v);
    v = '{'{lo, lo, lo}, '{hi, lo, lo}, '{lo, hi, lo}};
    send_face(OP_ADD, v);
    v = '{'{hi, hi, hi}, '{lo, hi, hi}, '{hi, lo, lo}};
    send_face(OP_ADD, v);
    v = '{'{lo, hi, lo}, '{hi, lo, hi}, '{lo, lo, hi}};
    send_face(OP_ADD, v);
    v = '{'{5, 5, 5}, '{5, 5, 5}, '{5, 5, 5}};
    send_face(OP_ADD, v);
    v = '{'{0, 0, 0}, '{1, 2, 3}, '{2, 4, 6}};
    send_face(OP_ADD, v);
    v = '{'{0, 0, 0}, '{1, 1, 0}, '{0, 1, 1}};
    send_face(OP_ADD, v);
    v = '{'{hi, lo, hi}, '{lo, hi, lo}, '{-1, -1, -1}};
    send_face(OP_CLEAR, v);
    v = '{'{-3, 7, 0}, '{4, -2, 9}, '{0, 0, -8}};
    send_face(OP_ADD, v);
    v = '{'{0, 0, 0}, '{1, 1, 1}, '{-1, 2, -1}};
    send_face(OP_ADD, v);
    send_face(OP_CLEAR, v);
    send_face(OP_CLEAR, v);
    // segment setting and the odd register values, all of which act as two
    for (int s = 0; s < 3; s++) begin
      write_verts(s[1:0]);
      v = '{'{lo, 3, hi}, '{hi, -3, lo}, '{hi, hi, hi}};
      send_face(OP_ADD, v);
      v = '{'{1, 2, 3}, '{1, 2, 3}, '{lo, lo, lo}};
      send_face(OP_ADD, v);
    end
    write_verts(TRI_MODE);
  endtask

  task automatic test_random_phase(int idle, int stall, logic [1:0] verts, int n);
    write_verts(verts);
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < n; i++) send_random_face();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random_phase(0, 0, TRI_MODE, 350);
    test_random_phase(84, 0, 2'd2, 150);
    test_random_phase(0, 84, TRI_MODE, 350);
    test_random_phase(11, 11, 2'd0, 60);
    test_random_phase(11, 11, 2'd1, 60);
    test_random_phase(84, 84, TRI_MODE, 100);
    test_random_phase(11, 11, TRI_MODE, 260);
    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/fnb_pkg.sv
design/fnb_mul.sv
design/fnb_sqrt.sv
design/fnb_div.sv
design/face_normal_and_bounds.sv
design/fnb_checker.sv
sim/tb.sv
